### design/dpc_pkg.sv
// Shared types, widths and reset values for the deadband proportional controller.
package dpc_pkg;

    localparam int unsigned ValueWidth    = 24;
    localparam int unsigned ErrorWidth    = 25;
    localparam int unsigned DeadbandWidth = 23;
    localparam int unsigned GainWidth     = 16;
    localparam int unsigned DriveWidth    = 16;
    localparam int unsigned ClampWidth    = 15;
    localparam int unsigned CountWidth    = 16;
    localparam int unsigned ProdWidth     = ValueWidth + GainWidth;
    localparam int unsigned ProdShift     = 10;
    localparam int unsigned ScaledWidth   = ProdWidth - ProdShift;
    localparam int unsigned CfgAddrWidth  = 3;
    localparam int unsigned CfgDataWidth  = 23;
    localparam int unsigned InDataWidth   = 48;
    localparam int unsigned OutDataWidth  = 24;

    localparam logic [DeadbandWidth-1:0]   DeadbandReset    = 23'd256;
    localparam logic [GainWidth-1:0]       GainReset        = 16'd1311;
    localparam logic [ClampWidth-1:0]      MaxPositiveReset = 15'd16384;
    localparam logic signed [DriveWidth-1:0] MaxNegativeReset = -16'sd16384;
    localparam logic [ClampWidth-1:0]      MinPositiveReset = 15'd0;
    localparam logic signed [DriveWidth-1:0] MinNegativeReset = 16'sd0;
    localparam logic [CountWidth-1:0]      SettleTicksReset = 16'd10;

    typedef enum logic [CfgAddrWidth-1:0] {
        CFG_ERROR_DEADBAND = 3'd0,
        CFG_LOOP_GAIN      = 3'd1,
        CFG_MAX_POSITIVE   = 3'd2,
        CFG_MAX_NEGATIVE   = 3'd3,
        CFG_MIN_POSITIVE   = 3'd4,
        CFG_MIN_NEGATIVE   = 3'd5,
        CFG_SETTLE_TICKS   = 3'd6
    } cfg_index_t;

endpackage

### design/deadband_proportional_control_top.sv
// Top level of the deadband proportional controller: two-register pipeline.
// A word accepted into the input register goes through one pass of logic into the result
// register, which holds it on m_tdata until the sink takes it.
// Throughput: one word per cycle; both registers advance whenever the result register
// is empty or handing its word on, so only m_tready stalls the pipe (two words held).
// Reset (aresetn, synchronous, active low) empties the pipe, clears the settle
// counter and the done flag, and loads every configuration register with its default.
module deadband_proportional_control_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [dpc_pkg::CfgAddrWidth-1:0] cfg_addr,
    input  logic [dpc_pkg::CfgDataWidth-1:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [dpc_pkg::InDataWidth-1:0]  s_tdata,  // [23:0] measured, [47:24] target
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [dpc_pkg::OutDataWidth-1:0] m_tdata   // [15:0] drive, [16] settled, rest 0
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dpc_pkg::DeadbandWidth-1:0]      deadband_reg;
    logic [dpc_pkg::GainWidth-1:0]          gain_reg;
    logic [dpc_pkg::ClampWidth-1:0]         max_pos_reg;
    logic signed [dpc_pkg::DriveWidth-1:0]  max_neg_reg;
    logic [dpc_pkg::ClampWidth-1:0]         min_pos_reg;
    logic signed [dpc_pkg::DriveWidth-1:0]  min_neg_reg;
    logic [dpc_pkg::CountWidth-1:0]         settle_ticks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg     <= dpc_pkg::DeadbandReset;
            gain_reg         <= dpc_pkg::GainReset;
            max_pos_reg      <= dpc_pkg::MaxPositiveReset;
            max_neg_reg      <= dpc_pkg::MaxNegativeReset;
            min_pos_reg      <= dpc_pkg::MinPositiveReset;
            min_neg_reg      <= dpc_pkg::MinNegativeReset;
            settle_ticks_reg <= dpc_pkg::SettleTicksReset;
        end else if (cfg_wr_en) begin
            // Indexes past the list fall through and are dropped.
            unique case (dpc_pkg::cfg_index_t'(cfg_addr))
                dpc_pkg::CFG_ERROR_DEADBAND: deadband_reg <= cfg_wdata;
                dpc_pkg::CFG_LOOP_GAIN:      gain_reg     <= cfg_wdata[dpc_pkg::GainWidth-1:0];
                dpc_pkg::CFG_MAX_POSITIVE:   max_pos_reg  <= cfg_wdata[dpc_pkg::ClampWidth-1:0];
                dpc_pkg::CFG_MAX_NEGATIVE:   max_neg_reg  <= cfg_wdata[dpc_pkg::DriveWidth-1:0];
                dpc_pkg::CFG_MIN_POSITIVE:   min_pos_reg  <= cfg_wdata[dpc_pkg::ClampWidth-1:0];
                dpc_pkg::CFG_MIN_NEGATIVE:   min_neg_reg  <= cfg_wdata[dpc_pkg::DriveWidth-1:0];
                dpc_pkg::CFG_SETTLE_TICKS:
                    settle_ticks_reg <= cfg_wdata[dpc_pkg::CountWidth-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a register loads if empty, or if the next is empty or moving
    // ------------------------------------------------------------------
    logic in_valid_reg, out_valid_reg;
    logic out_load, in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign in_load  = !in_valid_reg  || out_load;
    assign s_tready = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load)  in_valid_reg  <= s_tvalid;
            if (out_load) out_valid_reg <= in_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the input word
    // ------------------------------------------------------------------
    logic signed [dpc_pkg::ValueWidth-1:0] meas_reg, targ_reg;

    always_ff @(posedge aclk) begin
        if (in_load) begin
            meas_reg <= s_tdata[dpc_pkg::ValueWidth-1:0];
            targ_reg <= s_tdata[2*dpc_pkg::ValueWidth-1:dpc_pkg::ValueWidth];
        end
    end

    // ------------------------------------------------------------------
    // Error, magnitude, deadband test and the gain product
    // ------------------------------------------------------------------
    logic signed [dpc_pkg::ErrorWidth-1:0] err;
    logic [dpc_pkg::ErrorWidth-1:0]        err_abs;
    logic [dpc_pkg::ValueWidth-1:0]        mag;
    logic                                  outside;
    logic                                  err_neg;
    logic [dpc_pkg::ProdWidth-1:0]         prod;
    logic [dpc_pkg::ScaledWidth-1:0]       scaled;  // Q.14 magnitude, truncated

    always_comb begin
        err     = {targ_reg[dpc_pkg::ValueWidth-1], targ_reg}
                - {meas_reg[dpc_pkg::ValueWidth-1], meas_reg};
        err_neg = err[dpc_pkg::ErrorWidth-1];
        err_abs = err_neg ? (~err + 1'b1) : err;
        // |error| never exceeds 2^24 - 1, so the top bit is always clear
        mag     = err_abs[dpc_pkg::ValueWidth-1:0];
        outside = mag > {1'b0, deadband_reg};
        prod    = {{dpc_pkg::GainWidth{1'b0}}, mag} * {{dpc_pkg::ValueWidth{1'b0}}, gain_reg};
        scaled  = prod[dpc_pkg::ProdWidth-1:dpc_pkg::ProdShift];
    end

    // ------------------------------------------------------------------
    // Saturate, clamp, apply minimum drive, update settle state
    // ------------------------------------------------------------------
    // Compare in 17 bits so the unsigned 15-bit limits and signed 16-bit
    // limits line up with the signed drive.
    logic signed [dpc_pkg::DriveWidth:0] sat;
    logic signed [dpc_pkg::DriveWidth:0] clamped;
    logic signed [dpc_pkg::DriveWidth:0] drive_full;
    logic signed [dpc_pkg::DriveWidth:0] max_pos_ext, max_neg_ext, min_pos_ext, min_neg_ext;
    logic        hi_pos, hi_neg;

    always_comb begin
        max_pos_ext = {2'b00, max_pos_reg};
        min_pos_ext = {2'b00, min_pos_reg};
        max_neg_ext = {max_neg_reg[dpc_pkg::DriveWidth-1], max_neg_reg};
        min_neg_ext = {min_neg_reg[dpc_pkg::DriveWidth-1], min_neg_reg};

        // Magnitude past the 16-bit range on either side
        hi_pos = |scaled[dpc_pkg::ScaledWidth-1:dpc_pkg::DriveWidth-1];
        hi_neg = |scaled[dpc_pkg::ScaledWidth-1:dpc_pkg::DriveWidth]
              || (scaled[dpc_pkg::DriveWidth-1]
                  && |scaled[dpc_pkg::DriveWidth-2:0]);

        if (err_neg) begin
            sat = hi_neg ? -17'sd32768
                         : -$signed({1'b0, scaled[dpc_pkg::DriveWidth-1:0]});
        end else begin
            sat = hi_pos ? 17'sd32767
                         : $signed({2'b00, scaled[dpc_pkg::DriveWidth-2:0]});
        end

        priority if (sat > max_pos_ext) begin
            clamped = max_pos_ext;
        end else if (sat < max_neg_ext) begin
            clamped = max_neg_ext;
        end else begin
            clamped = sat;
        end

        // Raise a nonzero drive to the minimum magnitude; zero stays zero.
        priority if (clamped > 17'sd0 && clamped < min_pos_ext) begin
            drive_full = min_pos_ext;
        end else if (clamped < 17'sd0 && clamped > min_neg_ext) begin
            drive_full = min_neg_ext;
        end else begin
            drive_full = clamped;
        end
    end

    // Settle counter and sticky done flag advance once per word leaving the input register.
    logic [dpc_pkg::CountWidth-1:0] settle_count_reg, settle_count_next;
    logic                           done_reg, done_next;
    logic [dpc_pkg::CountWidth-1:0] count_inc;
    logic                           in_move;

    assign in_move   = in_valid_reg && out_load;
    assign count_inc = settle_count_reg + 1'b1;

    always_comb begin
        settle_count_next = settle_count_reg;
        done_next         = done_reg;
        if (in_move) begin
            if (outside) begin
                settle_count_next = '0;
            end else if (count_inc >= settle_ticks_reg) begin
                settle_count_next = '0;
                done_next         = 1'b1;
            end else begin
                settle_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_count_reg <= '0;
            done_reg         <= 1'b0;
        end else begin
            settle_count_reg <= settle_count_next;
            done_reg         <= done_next;
        end
    end

    // Result register: hold while the sink stalls.
    logic signed [dpc_pkg::DriveWidth-1:0] drive_reg;
    logic                                  settled_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            drive_reg   <= outside ? drive_full[dpc_pkg::DriveWidth-1:0] : '0;
            settled_reg <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dpc_pkg::OutDataWidth-dpc_pkg::DriveWidth-1){1'b0}},
                       settled_reg, drive_reg};

endmodule

### test/tb_top.sv
// Self-checking testbench for the deadband proportional controller: directed and random stimulus.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Extremes of a measured or target word.
    localparam logic signed [dpc_pkg::ValueWidth-1:0] ValueMax =
        {1'b0, {(dpc_pkg::ValueWidth-1){1'b1}}};
    localparam logic signed [dpc_pkg::ValueWidth-1:0] ValueMin =
        {1'b1, {(dpc_pkg::ValueWidth-1){1'b0}}};

    // One result word as the block should produce it.
    typedef struct packed {
        logic signed [dpc_pkg::DriveWidth-1:0] drive;
        logic                                  settled;
    } drive_word_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    dpc_pkg::cfg_index_t              cfg_addr  = dpc_pkg::CFG_ERROR_DEADBAND;
    logic [dpc_pkg::CfgDataWidth-1:0] cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [dpc_pkg::InDataWidth-1:0]  s_tdata   = '0;   // [23:0] measured, [47:24] target
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [dpc_pkg::OutDataWidth-1:0] m_tdata;          // [15:0] drive, [16] settled, rest 0

    // Shadow copy of the register file, loaded with the block's reset values.
    logic [dpc_pkg::DeadbandWidth-1:0]     band_limit    = dpc_pkg::DeadbandReset;
    logic [dpc_pkg::GainWidth-1:0]         gain          = dpc_pkg::GainReset;
    logic [dpc_pkg::ClampWidth-1:0]        pos_ceiling   = dpc_pkg::MaxPositiveReset;
    logic signed [dpc_pkg::DriveWidth-1:0] neg_floor     = dpc_pkg::MaxNegativeReset;
    logic [dpc_pkg::ClampWidth-1:0]        pos_minimum   = dpc_pkg::MinPositiveReset;
    logic signed [dpc_pkg::DriveWidth-1:0] neg_minimum   = dpc_pkg::MinNegativeReset;
    logic [dpc_pkg::CountWidth-1:0]        settle_target = dpc_pkg::SettleTicksReset;

    // Shadow copy of the controller state.
    logic [dpc_pkg::CountWidth-1:0] settle_run   = '0;
    logic                           settled_seen = 1'b0;

    drive_word_t pending_drives[$];
    drive_word_t oldest;

    // Handshake pacing knobs, set per test.
    bit          tx_idle_en      = 1'b0;
    bit          rx_stall_en     = 1'b0;
    int unsigned rx_hold_request = 0;
    int unsigned rx_stall_left   = 0;

    // Run statistics.
    int unsigned fail_count     = 0;
    int unsigned words_sent     = 0;
    int unsigned words_checked  = 0;
    int unsigned band_ticks     = 0;
    int unsigned limited_words  = 0;
    int unsigned input_stalls   = 0;
    int unsigned settings_count = 0;

    deadband_proportional_control_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [23:0] measured, [47:24] target
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [15:0] drive, [16] settled, rest 0
    );

    always #2 aclk = ~aclk;

    // Control law for one tick: advance the settle state and return the drive word.
    function automatic drive_word_t control_law(
            input logic signed [dpc_pkg::ValueWidth-1:0] measured,
            input logic signed [dpc_pkg::ValueWidth-1:0] target);
        longint      err;
        longint      mag;
        longint      prod;
        longint      drv;
        longint      raw;
        drive_word_t word;
        err = longint'(target) - longint'(measured);
        mag = (err < 0) ? -err : err;
        drv = 0;
        if (mag > longint'(band_limit)) begin
            settle_run = '0;
            // Q.8 times Q.16 is Q.24; drop ten bits to reach Q.14, truncating the magnitude.
            prod = (mag * longint'(gain)) >>> dpc_pkg::ProdShift;
            if (err < 0) begin
                drv = (prod > 32768) ? -32768 : -prod;
            end else begin
                drv = (prod > 32767) ? 32767 : prod;
            end
            raw = (err < 0) ? -prod : prod;
            // Clamp to the maxima first; the minimum step comes last and wins.
            if (drv > longint'(pos_ceiling)) begin
                drv = longint'(pos_ceiling);
            end else if (drv < longint'(neg_floor)) begin
                drv = longint'(neg_floor);
            end
            // A drive that truncated to zero stays zero.
            if (drv > 0 && drv < longint'(pos_minimum)) begin
                drv = longint'(pos_minimum);
            end else if (drv < 0 && drv > longint'(neg_minimum)) begin
                drv = longint'(neg_minimum);
            end
            if (drv != raw) limited_words++;
        end else begin
            band_ticks++;
            settle_run = settle_run + 1'b1;
            // Compare with the live register, so a lowered settle time ends the count at once.
            if (settle_run >= settle_target) begin
                settle_run   = '0;
                settled_seen = 1'b1;
            end
        end
        word.drive   = dpc_pkg::DriveWidth'(drv);
        word.settled = settled_seen;
        return word;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // Write one register and mirror it in the shadow copy; call only while idle.
    task automatic write_reg(input dpc_pkg::cfg_index_t index,
                             input logic [dpc_pkg::CfgDataWidth-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (index)
            dpc_pkg::CFG_ERROR_DEADBAND: band_limit    = value[dpc_pkg::DeadbandWidth-1:0];
            dpc_pkg::CFG_LOOP_GAIN:      gain          = value[dpc_pkg::GainWidth-1:0];
            dpc_pkg::CFG_MAX_POSITIVE:   pos_ceiling   = value[dpc_pkg::ClampWidth-1:0];
            dpc_pkg::CFG_MAX_NEGATIVE:   neg_floor     = value[dpc_pkg::DriveWidth-1:0];
            dpc_pkg::CFG_MIN_POSITIVE:   pos_minimum   = value[dpc_pkg::ClampWidth-1:0];
            dpc_pkg::CFG_MIN_NEGATIVE:   neg_minimum   = value[dpc_pkg::DriveWidth-1:0];
            dpc_pkg::CFG_SETTLE_TICKS:   settle_target = value[dpc_pkg::CountWidth-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [dpc_pkg::DeadbandWidth-1:0]     deadband,
                                 input logic [dpc_pkg::GainWidth-1:0]         new_gain,
                                 input logic [dpc_pkg::ClampWidth-1:0]        max_pos,
                                 input logic signed [dpc_pkg::DriveWidth-1:0] max_neg,
                                 input logic [dpc_pkg::ClampWidth-1:0]        min_pos,
                                 input logic signed [dpc_pkg::DriveWidth-1:0] min_neg,
                                 input logic [dpc_pkg::CountWidth-1:0]        ticks);
        write_reg(dpc_pkg::CFG_ERROR_DEADBAND, dpc_pkg::CfgDataWidth'(deadband));
        write_reg(dpc_pkg::CFG_LOOP_GAIN,      dpc_pkg::CfgDataWidth'(new_gain));
        write_reg(dpc_pkg::CFG_MAX_POSITIVE,   dpc_pkg::CfgDataWidth'(max_pos));
        write_reg(dpc_pkg::CFG_MAX_NEGATIVE,
                  {{(dpc_pkg::CfgDataWidth-dpc_pkg::DriveWidth){1'b0}}, max_neg});
        write_reg(dpc_pkg::CFG_MIN_POSITIVE,   dpc_pkg::CfgDataWidth'(min_pos));
        write_reg(dpc_pkg::CFG_MIN_NEGATIVE,
                  {{(dpc_pkg::CfgDataWidth-dpc_pkg::DriveWidth){1'b0}}, min_neg});
        write_reg(dpc_pkg::CFG_SETTLE_TICKS,   dpc_pkg::CfgDataWidth'(ticks));
        settings_count++;
    endtask

    // Drop valid and hold until every expected word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Offer one word, hold it until accepted, then record what it should produce.
    // Without an idle gap, valid stays high on return, so back-to-back words need no second assignment.
    task automatic send_word(input logic signed [dpc_pkg::ValueWidth-1:0] measured,
                             input logic signed [dpc_pkg::ValueWidth-1:0] target);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {target, measured};
        @(posedge aclk);
        while (!s_tready) begin
            input_stalls++;
            @(posedge aclk);
        end
        pending_drives.push_back(control_law(measured, target));
        words_sent++;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 99) < 30) gap = idle_length();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Send a word whose error is the given offset (negated or clipped at the range ends) at a random operating point.
    task automatic send_offset(input longint offset);
        longint measured;
        longint target;
        measured = longint'($urandom_range(0, 32'hFFFFFF)) - 64'sd8388608;
        target   = measured + offset;
        if (target > 8388607 || target < -8388608) target = measured - offset;
        if (target > 8388607) begin
            target = 8388607;
        end else if (target < -8388608) begin
            target = -8388608;
        end
        send_word(dpc_pkg::ValueWidth'(measured), dpc_pkg::ValueWidth'(target));
    endtask

    // Random word: errors around the deadband edge, errors of every scale, and raw noise.
    task automatic send_random_word();
        int unsigned pick;
        int unsigned span;
        longint      reach;
        longint      offset;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            reach = longint'(band_limit) + 3;
            send_offset(longint'($urandom_range(0, 32'(2 * reach))) - reach);
        end else if (pick < 75) begin
            span   = $urandom_range(1, 24);
            offset = longint'($urandom_range(0, (32'd1 << span) - 1));
            send_offset(($urandom_range(0, 1) != 0) ? offset : -offset);
        end else begin
            send_word(dpc_pkg::ValueWidth'($urandom()), dpc_pkg::ValueWidth'($urandom()));
        end
    endtask

    // Reset values: deadband edges, both input extremes, equal extremes.
    task automatic test_reset_values();
        send_word(24'sd0, 24'sd0);
        send_word(24'sd0, 24'sd256);
        send_word(24'sd0, -24'sd256);
        send_word(24'sd0, 24'sd257);
        send_word(24'sd0, -24'sd257);
        send_word(ValueMin, ValueMax);
        send_word(ValueMax, ValueMin);
        send_word(ValueMax, ValueMax);
        send_word(ValueMin, ValueMin);
    endtask

    // Build up a settle count under a long settle time, then lower it below the count.
    task automatic test_lowered_settle();
        wait_idle();
        write_reg(dpc_pkg::CFG_SETTLE_TICKS, dpc_pkg::CfgDataWidth'(16'd65535));
        repeat (3) send_offset(longint'($urandom_range(0, 512)) - 256);
        wait_idle();
        write_reg(dpc_pkg::CFG_SETTLE_TICKS, dpc_pkg::CfgDataWidth'(16'd1));
        send_offset(64'sd0);
    endtask

    // Saturation, clamp order, minimum raise, crossed limits and tiny products.
    task automatic test_clamp_order();
        wait_idle();
        load_settings(23'd0, 16'd65535, 15'd32767, 16'sh8000, 15'd0, 16'sd0, 16'd1);
        send_word(ValueMin, ValueMax);
        send_word(ValueMax, ValueMin);
        send_word(24'sd0, 24'sd1);
        send_word(24'sd0, -24'sd1);
        wait_idle();
        load_settings(23'd100, 16'd200, 15'd100, -16'sd100, 15'd50, -16'sd50, 16'd10);
        send_word(24'sd0, 24'sd101);
        send_word(24'sd0, -24'sd101);
        send_word(24'sd0, 24'sd1000);
        send_word(24'sd0, -24'sd1000);
        // Minima beyond the maxima: the raise wins; products under one step stay zero.
        wait_idle();
        load_settings(23'd100, 16'd2, 15'd20, -16'sd20, 15'd40, -16'sd40, 16'd10);
        send_word(24'sd0, 24'sd1000);
        send_word(24'sd0, -24'sd1000);
        send_word(24'sd0, 24'sd500);
        send_word(24'sd0, -24'sd500);
        wait_idle();
        load_settings(23'd8388607, 16'd0, 15'd0, 16'sd0, 15'd32767, 16'sh8000, 16'd65535);
        send_word(24'sd0, ValueMax);
        send_word(ValueMin, ValueMax);
    endtask

    // Hold the result side off while words keep coming, then pause the sender until drained.
    task automatic test_backpressure();
        wait_idle();
        load_settings(23'd256, 16'd1311, 15'd16384, -16'sd16384, 15'd100, -16'sd100, 16'd10);
        tx_idle_en      = 1'b0;
        rx_stall_en     = 1'b0;
        rx_hold_request = 200;
        repeat (40) send_random_word();
        wait_idle();
        repeat (40) send_random_word();
    endtask

    // Random settings per phase, with extremes in the first two and mixed pacing.
    task automatic test_random_settings();
        logic [dpc_pkg::DeadbandWidth-1:0] deadband;
        int unsigned                       phase;
        for (phase = 0; phase < 6; phase++) begin
            wait_idle();
            tx_idle_en  = (phase != 0) && (phase != 4);
            rx_stall_en = (phase != 0) && (phase != 2);
            if (phase == 0) begin
                load_settings(23'd0, 16'd65535, 15'd32767, 16'sh8000, 15'd0, 16'sd0, 16'd1);
            end else if (phase == 1) begin
                load_settings(23'd8388607, 16'd0, 15'd0, 16'sd0, 15'd32767, 16'sh8000,
                              16'd65535);
            end else begin
                case ($urandom_range(0, 3))
                    0:       deadband = dpc_pkg::DeadbandWidth'($urandom_range(0, 64));
                    1:       deadband = dpc_pkg::DeadbandWidth'($urandom_range(0, 4096));
                    2:       deadband = dpc_pkg::DeadbandWidth'($urandom_range(0, 65536));
                    default: deadband = dpc_pkg::DeadbandWidth'($urandom_range(0, 8388607));
                endcase
                load_settings(deadband,
                              dpc_pkg::GainWidth'($urandom_range(0, 65535)),
                              dpc_pkg::ClampWidth'($urandom_range(0, 32767)),
                              -dpc_pkg::DriveWidth'($urandom_range(0, 32768)),
                              dpc_pkg::ClampWidth'($urandom_range(0,
                                  ($urandom_range(0, 1) != 0) ? 300 : 32767)),
                              -dpc_pkg::DriveWidth'($urandom_range(0,
                                  ($urandom_range(0, 1) != 0) ? 300 : 32768)),
                              dpc_pkg::CountWidth'($urandom_range(1, 65535)));
            end
            repeat (170) send_random_word();
        end
    endtask

    // Result side pacing: a requested hold is counted down here, otherwise random stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_hold_request != 0) begin
                rx_stall_left   = rx_hold_request;
                rx_hold_request = 0;
            end else if (rx_stall_left == 0 && rx_stall_en && $urandom_range(0, 99) < 20) begin
                rx_stall_left = idle_length();
            end
            if (rx_stall_left != 0) begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drives.size() == 0) begin
                $error("result word %h arrived with nothing expected", m_tdata);
                fail_count++;
            end else begin
                oldest = pending_drives.pop_front();
                words_checked++;
                if (m_tdata[dpc_pkg::DriveWidth-1:0] !== oldest.drive) begin
                    $error("drive: expected %0d, got %0d", oldest.drive,
                           $signed(m_tdata[dpc_pkg::DriveWidth-1:0]));
                    fail_count++;
                end
                if (m_tdata[dpc_pkg::DriveWidth] !== oldest.settled) begin
                    $error("settled: expected %0b, got %0b", oldest.settled,
                           m_tdata[dpc_pkg::DriveWidth]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_lowered_settle();
        test_clamp_order();
        test_backpressure();
        test_random_settings();

        // Drain, then wait on so that any stray word would show.
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_drives.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (pending_drives.size() != 0) begin
            $error("%0d expected result words never arrived", pending_drives.size());
            fail_count++;
        end

        $display("Run covered %0d words (%0d checked) over %0d register settings.",
                 words_sent, words_checked, settings_count);
        $display("%0d ticks inside the deadband, %0d drives limited, %0d input stall cycles.",
                 band_ticks, limited_words, input_stalls);
        if (fail_count == 0) begin
            $display("[deadband_proportional_control_top] OK");
        end else begin
            $display("[deadband_proportional_control_top] ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #4_000_000;
        $display("[deadband_proportional_control_top] ERROR");
        $finish;
    end

endmodule
